// ===== design/acm_pkg.sv =====
// shared types, constants and helpers of the alpha map codec
package acm_pkg;

    // map geometry
    localparam int MAP_SIDE   = 64;
    localparam int MAP_PIXELS = MAP_SIDE * MAP_SIDE;
    localparam int ROW_BYTES  = MAP_SIDE / 2;
    localparam int HALF_MAP   = MAP_PIXELS / 2;

    // internal widths
    localparam int POS_W = $clog2(MAP_PIXELS) + 1;
    localparam int COL_W = $clog2(ROW_BYTES);
    localparam int ROW_W = $clog2(MAP_SIDE);

    // port field widths
    localparam int VALUE_W   = 8;
    localparam int RUN_W     = 7;
    localparam int POS_OUT_W = 12;
    localparam int MODE_W    = 2;

    // one row store entry holds a pixel pair
    localparam int PAIR_W = 2 * VALUE_W;

    localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(MAP_SIDE - 1);
    localparam logic [ROW_W-1:0] ROW_PENULT = ROW_W'(MAP_SIDE - 2);
    localparam logic [COL_W-1:0] COL_LAST   = COL_W'(ROW_BYTES - 1);
    localparam logic [POS_W-1:0] PIX_END    = POS_W'(MAP_PIXELS);
    localparam logic [POS_W-1:0] HALF_END   = POS_W'(HALF_MAP);
    localparam logic [POS_W-1:0] HALF_LAST  = POS_W'(HALF_MAP - 1);

    // header byte fields
    localparam int HDR_FILL_BIT = 7;

    // reciprocal of 17 in 4.12 fixed point, exact for all 8-bit values
    localparam logic [15:0] RECIP17 = 16'd241;

    typedef enum logic [MODE_W-1:0] {
        MODE_RLE    = 2'd0,
        MODE_RAW    = 2'd1,
        MODE_UNPACK = 2'd2,
        MODE_PACK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_FILL   = 2'd1,
        PH_COPY   = 2'd2
    } phase_t;

    // one or two results caused by one source byte
    typedef struct packed {
        logic                 two;
        logic                 mem_sel;
        logic [VALUE_W-1:0]   value0;
        logic [VALUE_W-1:0]   value1;
        logic [RUN_W-1:0]     len0;
        logic [POS_OUT_W-1:0] pos0;
        logic                 last0;
        logic                 last1;
    } pair_t;

    // row store access
    typedef struct packed {
        logic              we;
        logic              re;
        logic [COL_W-1:0]  waddr;
        logic [COL_W-1:0]  raddr;
        logic [PAIR_W-1:0] wdata;
    } ram_req_t;

    // floor(b / 17) by reciprocal multiply
    function automatic logic [3:0] div17(input logic [7:0] b);
        logic [15:0] prod;
        prod = 16'(b) * RECIP17;
        return prod[15:12];
    endfunction

endpackage

// ===== design/alpha_map_codec_unit.sv =====
// top level of the alpha map codec
//
// Source bytes of one 64x64 alpha map enter on the s_ channel, one beat per byte;
// s_first marks the first byte of a map and clears position and run parser.
// Pixel runs leave on the m_ channel as value, run_length, position and last.
// The coding mode is written on the cfg_ channel, which is always ready; a write also
// starts a new map. A write must be made only while the block is idle; the block
// itself does not enforce this. A result passes the pending stage, then the output
// register. Throughput: one byte per cycle in run-length, raw and pack modes while
// the receiver does not stall. In unpack mode each byte gives two pixel beats, and
// the next byte is taken only as the second beat of the last one moves out. Bytes
// that give no result are still taken. The last row in unpack mode is replayed
// from a 32-entry row store written during the row before it; the store needs no
// clearing. Reset (aresetn low at a clock edge) selects run-length mode, clears the
// map state and drops pending results. When the receiver stalls, the output beat
// holds and the next byte with a result enters the pending stage, after which
// s_ready stays low until the stall clears.
module alpha_map_codec_unit
    import acm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [MODE_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [VALUE_W-1:0]   s_data_byte,
    input  logic                 s_first,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [VALUE_W-1:0]   m_value,
    output logic [RUN_W-1:0]     m_run_length,
    output logic [POS_OUT_W-1:0] m_position,
    output logic                 m_last
);

    logic              accept;
    logic              pair_valid;
    pair_t             pair;
    ram_req_t          ram_req;
    logic [PAIR_W-1:0] rdata;

    assign accept = s_valid && s_ready;

    // byte decoder
    acm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .data_byte  (s_data_byte),
        .first      (s_first),
        .pair_valid (pair_valid),
        .pair       (pair),
        .ram_req    (ram_req)
    );

    // row store
    acm_row_ram u_row_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (rdata)
    );

    // result beats
    acm_out_stage u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept && pair_valid),
        .pair_in      (pair),
        .rdata        (rdata),
        .in_ready     (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_run_length (m_run_length),
        .m_position   (m_position),
        .m_last       (m_last)
    );

endmodule

// ===== design/acm_row_ram.sv =====
// row store: one pixel pair per entry, registered read
module acm_row_ram
    import acm_pkg::*;
(
    input  logic              aclk,
    input  ram_req_t          req,
    output logic [PAIR_W-1:0] rdata
);

    logic [PAIR_W-1:0] row_mem [ROW_BYTES];
    logic [PAIR_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            row_mem[req.waddr] <= req.wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= row_mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/acm_front.sv =====
// byte decoder: map state, run parser and row store requests
module acm_front
    import acm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [MODE_W-1:0]  cfg_data,
    input  logic               accept,
    input  logic [VALUE_W-1:0] data_byte,
    input  logic               first,
    output logic               pair_valid,
    output pair_t              pair,
    output ram_req_t           ram_req
);

    mode_t            mode_reg;
    phase_t           phase_reg, phase_next, phase_e;
    logic [POS_W-1:0] pos_reg, pos_next, pos_e;
    logic [RUN_W-1:0] rem_reg, rem_next, rem_e;
    logic [3:0]       held_reg, held_next, held_e;
    logic [POS_W-1:0] cnt_reg, cnt_next, cnt_e;
    logic [COL_W-1:0] col_reg, col_next, col_e;
    logic [ROW_W-1:0] row_reg, row_next, row_e;

    logic             cfg_write;
    logic             pix_full;
    logic             half_full;
    logic [POS_W-1:0] room;
    logic [RUN_W-1:0] fill_len;
    logic [POS_W-1:0] pos_unp;
    logic [3:0]       lo_nib, hi_nib, pk_nib;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // a new map clears position and parser before the byte is used
    assign phase_e = first ? PH_HEADER : phase_reg;
    assign pos_e   = first ? '0 : pos_reg;
    assign rem_e   = first ? '0 : rem_reg;
    assign held_e  = first ? '0 : held_reg;
    assign cnt_e   = first ? '0 : cnt_reg;
    assign col_e   = first ? '0 : col_reg;
    assign row_e   = first ? '0 : row_reg;

    assign pix_full  = (pos_e >= PIX_END);
    assign half_full = (pos_e >= HALF_END);

    // fill run cut to the pixels left in the map
    assign room     = PIX_END - pos_e;
    assign fill_len = (POS_W'(rem_e) > room) ? RUN_W'(room) : rem_e;

    assign pos_unp = {cnt_e[POS_W-2:0], 1'b0};
    assign lo_nib  = data_byte[3:0];
    assign hi_nib  = (col_e == COL_LAST) ? data_byte[3:0] : data_byte[7:4];
    assign pk_nib  = div17(data_byte);

    // run parser next state
    always_comb begin
        phase_next = phase_e;
        if (mode_reg == MODE_RLE && !pix_full) begin
            unique case (phase_e)
                PH_HEADER: begin
                    if (data_byte[HDR_FILL_BIT]) begin
                        phase_next = PH_FILL;
                    end else if (data_byte[RUN_W-1:0] != '0) begin
                        phase_next = PH_COPY;
                    end
                end
                PH_FILL: phase_next = PH_HEADER;
                PH_COPY: begin
                    if (rem_e <= RUN_W'(1)) begin
                        phase_next = PH_HEADER;
                    end
                end
                default: phase_next = PH_HEADER;
            endcase
        end
    end

    // results, counters and row store access per mode
    always_comb begin
        pair       = '0;
        pair_valid = 1'b0;
        ram_req    = '0;
        pos_next   = pos_e;
        rem_next   = rem_e;
        held_next  = held_e;
        cnt_next   = cnt_e;
        col_next   = col_e;
        row_next   = row_e;
        case (mode_reg)
            MODE_RLE: begin
                if (!pix_full) begin
                    case (phase_e)
                        PH_HEADER: rem_next = data_byte[RUN_W-1:0];
                        PH_FILL: begin
                            rem_next = '0;
                            if (fill_len != '0) begin
                                pair_valid  = 1'b1;
                                pair.value0 = data_byte;
                                pair.len0   = fill_len;
                                pair.pos0   = POS_OUT_W'(pos_e);
                                pair.last0  = (pos_e + POS_W'(fill_len)) == PIX_END;
                                pos_next    = pos_e + POS_W'(fill_len);
                            end
                        end
                        default: begin
                            pair_valid  = 1'b1;
                            pair.value0 = data_byte;
                            pair.len0   = RUN_W'(1);
                            pair.pos0   = POS_OUT_W'(pos_e);
                            pair.last0  = (pos_e + POS_W'(1)) == PIX_END;
                            pos_next    = pos_e + POS_W'(1);
                            if (rem_e != '0) begin
                                rem_next = rem_e - RUN_W'(1);
                            end
                        end
                    endcase
                end
            end
            MODE_RAW: begin
                if (!pix_full) begin
                    pair_valid  = 1'b1;
                    pair.value0 = data_byte;
                    pair.len0   = RUN_W'(1);
                    pair.pos0   = POS_OUT_W'(pos_e);
                    pair.last0  = (pos_e + POS_W'(1)) == PIX_END;
                    pos_next    = pos_e + POS_W'(1);
                    cnt_next    = cnt_e + POS_W'(1);
                end
            end
            MODE_UNPACK: begin
                if (cnt_e < HALF_END) begin
                    pair_valid = 1'b1;
                    pair.two   = 1'b1;
                    pair.len0  = RUN_W'(1);
                    pair.pos0  = POS_OUT_W'(pos_unp);
                    pair.last1 = (cnt_e == HALF_LAST);
                    if (row_e == ROW_LAST) begin
                        // last row repeats the stored one, read only on the taken beat
                        pair.mem_sel  = 1'b1;
                        ram_req.re    = accept;
                        ram_req.raddr = col_e;
                    end else begin
                        // times 17 is the nibble written twice
                        pair.value0 = {lo_nib, lo_nib};
                        pair.value1 = {hi_nib, hi_nib};
                        if (row_e == ROW_PENULT) begin
                            ram_req.we    = accept;
                            ram_req.waddr = col_e;
                            ram_req.wdata = {hi_nib, hi_nib, lo_nib, lo_nib};
                        end
                    end
                    pos_next = pos_unp + POS_W'(2);
                    cnt_next = cnt_e + POS_W'(1);
                    if (col_e == COL_LAST) begin
                        col_next = '0;
                        row_next = row_e + ROW_W'(1);
                    end else begin
                        col_next = col_e + COL_W'(1);
                    end
                end
            end
            default: begin
                if (!half_full) begin
                    if (!cnt_e[0]) begin
                        held_next = pk_nib;
                    end else begin
                        pair_valid  = 1'b1;
                        pair.value0 = {pk_nib, held_e};
                        pair.len0   = RUN_W'(1);
                        pair.pos0   = POS_OUT_W'(pos_e);
                        pair.last0  = (pos_e + POS_W'(1)) == HALF_END;
                        pos_next    = pos_e + POS_W'(1);
                    end
                    cnt_next = cnt_e + POS_W'(1);
                end
            end
        endcase
    end

    // state registers, a mode write also starts a new map
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_RLE;
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            rem_reg   <= '0;
            held_reg  <= '0;
            cnt_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else if (cfg_write) begin
            mode_reg  <= mode_t'(cfg_data);
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            rem_reg   <= '0;
            held_reg  <= '0;
            cnt_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            held_reg  <= held_next;
            cnt_reg   <= cnt_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

`ifndef SYNTHESIS
    // a byte never both writes and reads the row store
    a_ram_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_req.we && ram_req.re))
        else $error("row store read and write from one byte");

    // stored pixels only come back as a pair
    a_mem_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && pair_valid && pair.mem_sel |-> pair.two && ram_req.re)
        else $error("row store result without pair read");

    // every taken result covers at least one position
    a_pair_len: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && pair_valid |-> pair.len0 != '0)
        else $error("empty run from a byte");
`endif

endmodule

// ===== design/acm_out_stage.sv =====
// result stage: splits pairs into beats and holds the output register
module acm_out_stage
    import acm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  pair_t                pair_in,
    input  logic [PAIR_W-1:0]    rdata,
    output logic                 in_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [VALUE_W-1:0]   m_value,
    output logic [RUN_W-1:0]     m_run_length,
    output logic [POS_OUT_W-1:0] m_position,
    output logic                 m_last
);

    logic                 p_valid_reg;
    logic                 p_sel_reg;
    pair_t                p_reg;

    logic                 m_valid_reg;
    logic [VALUE_W-1:0]   m_value_reg;
    logic [RUN_W-1:0]     m_run_length_reg;
    logic [POS_OUT_W-1:0] m_position_reg;
    logic                 m_last_reg;

    logic                 out_take;
    logic                 p_move;
    logic                 p_done;
    logic [VALUE_W-1:0]   cur_value;
    logic [RUN_W-1:0]     cur_len;
    logic [POS_OUT_W-1:0] cur_pos;
    logic                 cur_last;

    // handshake between pending pair and output register
    assign out_take = !m_valid_reg || m_ready;
    assign p_move   = p_valid_reg && out_take;
    assign p_done   = p_move && (!p_reg.two || p_sel_reg);
    assign in_ready = !p_valid_reg || p_done;

    // select the result that goes out next
    always_comb begin
        if (p_sel_reg) begin
            cur_value = p_reg.mem_sel ? rdata[PAIR_W-1:VALUE_W] : p_reg.value1;
            cur_len   = RUN_W'(1);
            cur_pos   = p_reg.pos0 + POS_OUT_W'(1);
            cur_last  = p_reg.last1;
        end else begin
            cur_value = p_reg.mem_sel ? rdata[VALUE_W-1:0] : p_reg.value0;
            cur_len   = p_reg.len0;
            cur_pos   = p_reg.pos0;
            cur_last  = p_reg.last0;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            p_sel_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                p_valid_reg <= 1'b1;
                p_sel_reg   <= 1'b0;
            end else if (p_done) begin
                p_valid_reg <= 1'b0;
            end else if (p_move) begin
                p_sel_reg <= 1'b1;
            end
            if (p_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            p_reg <= pair_in;
        end
        if (p_move) begin
            m_value_reg      <= cur_value;
            m_run_length_reg <= cur_len;
            m_position_reg   <= cur_pos;
            m_last_reg       <= cur_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_run_length = m_run_length_reg;
    assign m_position   = m_position_reg;
    assign m_last       = m_last_reg;

`ifndef SYNTHESIS
    // a new pair only lands on a free or finishing stage
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!p_valid_reg || p_done))
        else $error("pending pair overwritten");

    // second beat only for pairs
    a_sel_two: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg && p_sel_reg |-> p_reg.two)
        else $error("second beat of a single result");

    // no empty runs leave the block
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_run_length_reg != '0)
        else $error("run of length zero");
`endif

endmodule

// ===== test/tb_alpha_map_codec_unit.sv =====
// self-checking testbench of the alpha map codec top level
`timescale 1ns / 100ps

module tb_alpha_map_codec_unit;
    import acm_pkg::*;

    localparam int CYCLE_LIMIT = 300_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT = 2000;

    // one source byte waiting to be sent
    typedef struct {
        logic [VALUE_W-1:0] data;
        logic               first;
        bit                 hold;
    } src_item_t;

    // one pixel run as it leaves the block
    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [RUN_W-1:0]     run_len;
        logic [POS_OUT_W-1:0] pos;
        logic                 last;
    } alpha_run_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [MODE_W-1:0]    cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [VALUE_W-1:0]   s_data_byte = '0;
    logic                 s_first = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [VALUE_W-1:0]   m_value;
    logic [RUN_W-1:0]     m_run_length;
    logic [POS_OUT_W-1:0] m_position;
    logic                 m_last;

    // byte source and run bookkeeping
    src_item_t  src_q[$];
    src_item_t  next_item;
    alpha_run_t pending_runs[$];
    alpha_run_t got_run;
    alpha_run_t want_run;
    int         queued_cnt = 0;
    int         accepted_cnt = 0;
    int         expected_cnt = 0;
    int         exp_total = 0;
    int         seen_cnt = 0;
    int         err_cnt = 0;
    int         src_idle = 0;
    int         sink_hold = 0;
    int         cycle_cnt;
    bit         s_quiet = 1'b0;
    bit         m_quiet = 1'b0;

    // predicted codec state
    mode_t              cur_mode = MODE_RLE;
    phase_t             run_ph = PH_HEADER;
    logic [POS_W-1:0]   pix_pos = '0;
    logic [RUN_W-1:0]   runs_left = '0;
    logic [3:0]         held_nib = '0;
    logic [POS_W-1:0]   byte_cnt = '0;
    logic [VALUE_W-1:0] row_mem [MAP_SIDE];

    alpha_map_codec_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_first      (s_first),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_run_length (m_run_length),
        .m_position   (m_position),
        .m_last       (m_last)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic void clear_map();
        pix_pos   = '0;
        run_ph    = PH_HEADER;
        runs_left = '0;
        held_nib  = '0;
        byte_cnt  = '0;
    endfunction

    function automatic void add_run(input logic [VALUE_W-1:0] v, input int len, input int pos,
                                    input bit fin);
        alpha_run_t r;
        r.value   = v;
        r.run_len = RUN_W'(len);
        r.pos     = POS_OUT_W'(pos);
        r.last    = fin;
        pending_runs = {pending_runs, r};
    endfunction

    // predict the runs caused by one source byte, returns how many
    function automatic int decode_byte(input logic [VALUE_W-1:0] b, input logic f);
        int n, len, room, row, col;
        logic [3:0] lo, hi, nib;
        logic [VALUE_W-1:0] v0, v1;
        n = 0;
        if (f) clear_map();
        case (cur_mode)
            MODE_RLE: begin
                if (pix_pos < MAP_PIXELS) begin
                    case (run_ph)
                        PH_HEADER: begin
                            runs_left = b[RUN_W-1:0];
                            if (b[HDR_FILL_BIT]) run_ph = PH_FILL;
                            else if (runs_left != 0) run_ph = PH_COPY;
                        end
                        PH_FILL: begin
                            // fill is cut to what is left of the map
                            room = MAP_PIXELS - int'(pix_pos);
                            len = int'(runs_left);
                            if (len > room) len = room;
                            if (len != 0) begin
                                add_run(b, len, int'(pix_pos),
                                        int'(pix_pos) + len == MAP_PIXELS);
                                pix_pos = pix_pos + POS_W'(len);
                                n = 1;
                            end
                            runs_left = '0;
                            run_ph = PH_HEADER;
                        end
                        default: begin
                            add_run(b, 1, int'(pix_pos), int'(pix_pos) + 1 == MAP_PIXELS);
                            pix_pos++;
                            n = 1;
                            if (runs_left != 0) runs_left--;
                            if (runs_left == 0) run_ph = PH_HEADER;
                        end
                    endcase
                end
            end
            MODE_RAW: begin
                if (pix_pos < MAP_PIXELS) begin
                    add_run(b, 1, int'(pix_pos), int'(pix_pos) + 1 == MAP_PIXELS);
                    pix_pos++;
                    byte_cnt++;
                    n = 1;
                end
            end
            MODE_UNPACK: begin
                if (byte_cnt < HALF_MAP) begin
                    row = int'(byte_cnt) / ROW_BYTES;
                    col = int'(byte_cnt) % ROW_BYTES;
                    if (row + 1 >= MAP_SIDE) begin
                        // last row replays the one before it
                        v0 = row_mem[2 * col];
                        v1 = row_mem[2 * col + 1];
                    end else begin
                        lo = b[3:0];
                        hi = (col == ROW_BYTES - 1) ? lo : b[7:4];
                        v0 = VALUE_W'(lo * 17);
                        v1 = VALUE_W'(hi * 17);
                        if (row + 2 == MAP_SIDE) begin
                            row_mem[2 * col]     = v0;
                            row_mem[2 * col + 1] = v1;
                        end
                    end
                    pix_pos = POS_W'(2 * byte_cnt);
                    add_run(v0, 1, int'(pix_pos), 1'b0);
                    add_run(v1, 1, int'(pix_pos) + 1, int'(pix_pos) + 2 == MAP_PIXELS);
                    pix_pos = pix_pos + POS_W'(2);
                    byte_cnt++;
                    n = 2;
                end
            end
            default: begin
                // first pixel of a pair is held, second one emits the byte
                nib = 4'(b / 17);
                if (pix_pos < HALF_MAP) begin
                    if (!byte_cnt[0]) begin
                        held_nib = nib;
                    end else begin
                        add_run({nib, held_nib}, 1, int'(pix_pos),
                                int'(pix_pos) + 1 == HALF_MAP);
                        pix_pos++;
                        n = 1;
                    end
                    byte_cnt++;
                end
            end
        endcase
        return n;
    endfunction

    function automatic string show_run(input alpha_run_t r);
        return $sformatf("value %02h run %0d pos %0d last %0b",
                         r.value, r.run_len, r.pos, r.last);
    endfunction

    function automatic void log_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function automatic void add_byte(input logic [VALUE_W-1:0] b, input logic f,
                                     input bit hold = 1'b0);
        src_item_t it;
        it.data  = b;
        it.first = f;
        it.hold  = hold;
        src_q = {src_q, it};
        queued_cnt++;
    endfunction

    // random map content; run-length streams are mostly well formed
    function automatic void add_stream(input mode_t m, input int n);
        int made, r, cnt;
        bit fresh;
        made  = 0;
        fresh = 1'b1;
        while (made < n) begin
            r = $urandom_range(0, 19);
            if (m != MODE_RLE || r >= 18) begin
                add_byte(VALUE_W'($urandom), fresh || ($urandom_range(0, 63) == 0) ||
                         (m == MODE_RLE && r == 19), $urandom_range(0, 199) == 0);
                made++;
            end else if (r < 8) begin
                cnt = (r == 0) ? 0 : (r < 3) ? $urandom_range(100, 127) : $urandom_range(1, 40);
                add_byte(VALUE_W'(8'h80 | cnt), fresh);
                add_byte(VALUE_W'($urandom), 1'b0);
                made += 2;
            end else begin
                cnt = (r == 8) ? 0 : (r == 9) ? $urandom_range(20, 127) : $urandom_range(1, 6);
                add_byte(VALUE_W'(cnt), fresh);
                repeat (cnt) add_byte(VALUE_W'($urandom), 1'b0);
                made += cnt + 1;
            end
            fresh = 1'b0;
        end
    endfunction

    // mode write once all runs are out and the block has settled
    task automatic switch_mode(input mode_t m);
        while (accepted_cnt != queued_cnt || seen_cnt < expected_cnt) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_mode = m;
        clear_map();
        @(negedge aclk);
    endtask

    // source side: sends queued bytes, predicts on every accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                exp_total += decode_byte(s_data_byte, s_first);
                accepted_cnt <= accepted_cnt + 1;
                src_idle = pick_gap(s_quiet);
                if ($urandom_range(0, 299) == 0) s_quiet = !s_quiet;
            end
            expected_cnt <= exp_total;
            if (!s_valid || s_ready) begin
                if (src_idle > 0) begin
                    src_idle--;
                    s_valid <= 1'b0;
                end else if (src_q.size() != 0 && (!src_q[0].hold || seen_cnt >= exp_total)) begin
                    next_item = src_q.pop_front();
                    s_data_byte <= next_item.data;
                    s_first     <= next_item.first;
                    s_valid     <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side: checks each run beat, stalls at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen_cnt <= seen_cnt + 1;
                got_run = {m_value, m_run_length, m_position, m_last};
                if (pending_runs.size() == 0) begin
                    log_error({"unexpected run: ", show_run(got_run)});
                end else begin
                    want_run = pending_runs.pop_front();
                    if (got_run.value !== want_run.value || got_run.run_len !== want_run.run_len ||
                        got_run.pos !== want_run.pos || got_run.last !== want_run.last) begin
                        log_error({"run mismatch: expected ", show_run(want_run),
                                   ", got ", show_run(got_run)});
                    end
                end
            end
            if (sink_hold == 0 && $urandom_range(0, 5) == 0) sink_hold = pick_gap(m_quiet);
            m_ready <= (sink_hold == 0);
            if (sink_hold > 0) sink_hold--;
            if ($urandom_range(0, 999) == 0) m_quiet = !m_quiet;
        end
    end

    // run limit
    initial begin
        for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge aclk);
        $display("tb_alpha_map_codec_unit: errors");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int i;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // run-length corners: fills, zero counts, copies, a held-off header
        switch_mode(MODE_RLE);
        add_byte(8'h83, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h02, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h7E, 1'b0);
        add_byte(8'h01, 1'b0, 1'b1);
        add_byte(8'h5A, 1'b0);

        // raw extremes
        switch_mode(MODE_RAW);
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b0);

        // unpack: nibble extremes
        switch_mode(MODE_UNPACK);
        add_byte(8'h0F, 1'b1);
        add_byte(8'hF0, 1'b0);
        add_byte(8'hA5, 1'b0);

        // pack: divide-by-17 boundaries
        switch_mode(MODE_PACK);
        add_byte(8'h10, 1'b1);
        add_byte(8'h11, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h22, 1'b0);
        add_byte(8'hEF, 1'b0);

        // random phases over all modes
        for (i = 0; i < 12; i++) begin
            switch_mode(i < 4 ? mode_t'(i) : mode_t'($urandom_range(0, 3)));
            add_stream(cur_mode, $urandom_range(50, 90));
        end

        // run-length map ending in a cut fill, then one ending in a copy
        switch_mode(MODE_RLE);
        repeat (33) begin
            add_byte(8'hFF, src_q.size() == 0);
            add_byte(VALUE_W'($urandom), 1'b0);
        end
        add_byte(VALUE_W'($urandom), 1'b0);
        add_byte(VALUE_W'($urandom), 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(VALUE_W'($urandom), 1'b0);
        repeat (31) begin
            add_byte(8'hFF, 1'b0);
            add_byte(VALUE_W'($urandom), 1'b0);
        end
        add_byte(8'h7F, 1'b0);
        repeat (40) add_byte(VALUE_W'($urandom), 1'b0);
        add_byte(8'h81, 1'b1);
        add_byte(8'h33, 1'b0);

        // drain and judge
        while (accepted_cnt != queued_cnt) @(posedge aclk);
        for (i = 0; i < DRAIN_LIMIT && seen_cnt < expected_cnt; i++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (pending_runs.size() != 0)
            log_error($sformatf("%0d runs never arrived", pending_runs.size()));
        if (err_cnt == 0) begin
            $display("tb_alpha_map_codec_unit: clean");
        end else begin
            $display("tb_alpha_map_codec_unit: errors");
        end
        $finish;
    end

endmodule
